[rtl/mnk_pkg.sv]
// Shared types, constants and helper functions for the Morse number keyer.
`default_nettype none

package mnk_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ON   = 2'd1,
        PH_OFF  = 2'd2,
        PH_GAP  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [3:0] hundreds;
        logic [3:0] tens;
        logic [3:0] units;
    } digits_t;

    localparam logic [15:0] DOT_TICKS_RESET = 16'd100;
    localparam logic [9:0]  MAX_NUMBER      = 10'd999;
    localparam logic [2:0]  ELEMS_PER_DIGIT = 3'd5;
    localparam logic [1:0]  DIGIT_COUNT     = 2'd3;

    // Five elements per digit, LSB first; 1 is a dot, 0 is a dash
    localparam logic [4:0] DIGIT_CODE [16] = '{
        5'h00, 5'h01, 5'h03, 5'h07, 5'h0f, 5'h1f, 5'h1e, 5'h1c,
        5'h18, 5'h10, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00
    };

    function automatic logic elem_is_dot(input logic [3:0] digit, input logic [2:0] elem);
        logic [4:0] code;
        code = DIGIT_CODE[digit];
        case (elem)
            3'd0:    elem_is_dot = code[0];
            3'd1:    elem_is_dot = code[1];
            3'd2:    elem_is_dot = code[2];
            3'd3:    elem_is_dot = code[3];
            3'd4:    elem_is_dot = code[4];
            default: elem_is_dot = 1'b0;
        endcase
    endfunction

endpackage

`default_nettype wire

[rtl/mnk_ifs.sv]
// Valid/ready channel interfaces for requests, results and configuration.
`default_nettype none

interface mnk_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [9:0] number;

    modport source (output valid, output req_type, output number, input ready);
    modport sink   (input valid, input req_type, input number, output ready);
endinterface

interface mnk_res_if;
    logic valid;
    logic ready;
    logic beep;
    logic busy_res;
    logic rejected;
    logic done_res;

    modport source (output valid, output beep, output busy_res, output rejected,
                    output done_res, input ready);
    modport sink   (input valid, input beep, input busy_res, input rejected,
                    input done_res, output ready);
endinterface

interface mnk_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] dot_ticks;

    modport source (output valid, output dot_ticks, input ready);
    modport sink   (input valid, input dot_ticks, output ready);
endinterface

`default_nettype wire

[rtl/mnk_digit_split.sv]
// Splits a value below 1000 into hundreds, tens and units by reciprocal multiply.
`default_nettype none

module mnk_digit_split
    import mnk_pkg::*;
(
    input  wire logic [9:0] number,
    output digits_t         digits
);

    logic [15:0] hund_prod;
    logic [3:0]  hund;
    logic [9:0]  hund_x100;
    logic [6:0]  rem;
    logic [13:0] tens_prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;

    // n*41 >> 12 equals n/100 for n below 1000
    assign hund_prod = {6'd0, number} * 16'd41;
    assign hund      = hund_prod[15:12];
    assign hund_x100 = {6'd0, hund} * 10'd100;
    assign rem       = 7'(number - hund_x100);

    // r*103 >> 10 equals r/10 for r below 100
    assign tens_prod = {7'd0, rem} * 14'd103;
    assign tens      = tens_prod[13:10];
    assign tens_x10  = {3'd0, tens} * 7'd10;

    assign digits.hundreds = hund;
    assign digits.tens     = tens;
    assign digits.units    = 4'(rem - tens_x10);

endmodule

`default_nettype wire

[rtl/morse_number_keyer.sv]
// Top level of the Morse number keyer.
// Takes one request per clock: a time tick (req_type 0) or a number to send
// (req_type 1, 0..999). Every request yields exactly one result, in the cycle after
// acceptance, held in an output register; a new request is taken whenever that
// register is empty or being drained in the same cycle, so the sustained rate is
// one request per clock. The result gives the beeper level, busy, rejected and
// done flags after the request. Dot length comes from the dot_ticks register
// (reset 100, zero acts as one); write it only while no number is being sent.
`default_nettype none

module morse_number_keyer
    import mnk_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    mnk_req_if.sink     req_ch,
    mnk_res_if.source   res_ch,
    mnk_cfg_if.sink     cfg_ch
);

    logic [15:0] dot_reg;
    digits_t     digits_reg, digits_next;
    logic [1:0]  dp_reg, dp_next;
    logic [2:0]  ep_reg, ep_next;
    phase_t      phase_reg, phase_next;
    logic [18:0] tr_reg, tr_next;

    logic        res_valid_reg, res_valid_next;
    logic        beep_reg, busy_reg, rej_reg, done_reg;

    logic        accept;
    logic        rejected, done;
    digits_t     split;
    logic [3:0]  first_digit;
    logic [15:0] d1;
    logic [18:0] len1, len3, len5;
    logic [18:0] dec;
    logic [2:0]  ep_inc;
    logic [1:0]  dp_inc;

    mnk_digit_split u_split (
        .number (req_ch.number),
        .digits (split)
    );

    function automatic logic [3:0] pick_digit(input digits_t d, input logic [1:0] p);
        case (p)
            2'd0:    pick_digit = d.hundreds;
            2'd1:    pick_digit = d.tens;
            2'd2:    pick_digit = d.units;
            default: pick_digit = 4'd0;
        endcase
    endfunction

    assign accept        = req_ch.valid && req_ch.ready;
    assign req_ch.ready  = !res_valid_reg || res_ch.ready;
    assign cfg_ch.ready  = 1'b1;

    assign d1    = (dot_reg == 16'd0) ? 16'd1 : dot_reg;
    assign len1  = {3'd0, d1};
    assign len3  = {2'd0, d1, 1'b0} + len1;
    assign len5  = {1'd0, d1, 2'b0} + len1;
    assign dec   = (tr_reg != 19'd0) ? tr_reg - 19'd1 : 19'd0;
    assign ep_inc      = ep_reg + 3'd1;
    assign dp_inc      = dp_reg + 2'd1;
    assign first_digit = (split.hundreds == 4'd0) ? split.tens : split.hundreds;

    // Next state of the sender
    always_comb
    begin
        digits_next = digits_reg;
        dp_next     = dp_reg;
        ep_next     = ep_reg;
        phase_next  = phase_reg;
        tr_next     = tr_reg;
        rejected    = 1'b0;
        done        = 1'b0;
        if (accept)
        begin
            if (req_ch.req_type)
            begin
                if (phase_reg != PH_IDLE || req_ch.number > MAX_NUMBER)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    digits_next = split;
                    dp_next     = (split.hundreds == 4'd0) ? 2'd1 : 2'd0;
                    ep_next     = 3'd0;
                    phase_next  = PH_ON;
                    tr_next     = elem_is_dot(first_digit, 3'd0) ? len1 : len3;
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                tr_next = dec;
                if (dec == 19'd0)
                begin
                    case (phase_reg)
                        PH_ON:
                        begin
                            phase_next = PH_OFF;
                            tr_next    = len1;
                        end
                        PH_OFF:
                        begin
                            ep_next = ep_inc;
                            if (ep_inc >= ELEMS_PER_DIGIT)
                            begin
                                phase_next = PH_GAP;
                                tr_next    = len5;
                            end
                            else
                            begin
                                phase_next = PH_ON;
                                tr_next    = elem_is_dot(pick_digit(digits_reg, dp_reg), ep_inc)
                                             ? len1 : len3;
                            end
                        end
                        PH_GAP:
                        begin
                            ep_next = 3'd0;
                            if (dp_inc >= DIGIT_COUNT)
                            begin
                                dp_next    = 2'd0;
                                phase_next = PH_IDLE;
                                tr_next    = 19'd0;
                                done       = 1'b1;
                            end
                            else
                            begin
                                dp_next    = dp_inc;
                                phase_next = PH_ON;
                                tr_next    = elem_is_dot(pick_digit(digits_reg, dp_inc), 3'd0)
                                             ? len1 : len3;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
        end
    end

    // Result register valid: load on a request, drop once taken
    always_comb
    begin
        if (accept)
            res_valid_next = 1'b1;
        else if (res_ch.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg       <= DOT_TICKS_RESET;
            digits_reg    <= '0;
            dp_reg        <= 2'd0;
            ep_reg        <= 3'd0;
            phase_reg     <= PH_IDLE;
            tr_reg        <= 19'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid)
                dot_reg <= cfg_ch.dot_ticks;
            digits_reg    <= digits_next;
            dp_reg        <= dp_next;
            ep_reg        <= ep_next;
            phase_reg     <= phase_next;
            tr_reg        <= tr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            beep_reg <= (phase_next == PH_ON);
            busy_reg <= (phase_next != PH_IDLE);
            rej_reg  <= rejected;
            done_reg <= done;
        end
    end

    assign res_ch.valid    = res_valid_reg;
    assign res_ch.beep     = beep_reg;
    assign res_ch.busy_res = busy_reg;
    assign res_ch.rejected = rej_reg;
    assign res_ch.done_res = done_reg;

endmodule

`default_nettype wire

[rtl/mnk_checker.sv]
// Port-level assertions for the Morse number keyer and their bind.
`default_nettype none

module mnk_checker
    import mnk_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       req_valid,
    input wire logic       req_ready,
    input wire logic       req_type,
    input wire logic [9:0] number,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic       beep,
    input wire logic       busy_res,
    input wire logic       rejected,
    input wire logic       done_res
);

    // Stalled result must hold
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(beep) && $stable(busy_res)
            && $stable(rejected) && $stable(done_res))
        else $error("result changed while stalled");

    a_beep_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && beep |-> busy_res)
        else $error("beep without busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && done_res |-> !busy_res && !beep && !rejected)
        else $error("done while still sending or rejecting");

    a_range_reject: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_type && number > MAX_NUMBER
            |=> res_valid && rejected && !done_res)
        else $error("out of range request not rejected");

endmodule

bind morse_number_keyer mnk_checker u_mnk_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_ch.valid),
    .req_ready (req_ch.ready),
    .req_type  (req_ch.req_type),
    .number    (req_ch.number),
    .res_valid (res_ch.valid),
    .res_ready (res_ch.ready),
    .beep      (res_ch.beep),
    .busy_res  (res_ch.busy_res),
    .rejected  (res_ch.rejected),
    .done_res  (res_ch.done_res)
);

`default_nettype wire
